@@ design/ctd_pkg.sv @@
// shared types and constants for the chunked transmission deframer
// used by ctd_parser and chunked_transmission_deframer; no dependencies
`default_nettype none

package ctd_pkg;

   // stream markers
   localparam logic [31:0] SIG_NATIVE  = 32'h0102_0304;
   localparam logic [31:0] SIG_SWAPPED = 32'h0403_0201;
   localparam logic [31:0] LEN_END     = 32'hFFFF_FFFF;
   localparam logic [7:0]  LINE_FEED   = 8'h0A;

   // number of signature and length bytes
   localparam logic [2:0]  FIELD_BYTES = 3'd4;

   // request command codes
   typedef enum logic {
      CMD_BYTE  = 1'b0,
      CMD_BEGIN = 1'b1
   } cmd_type;

   // result kinds
   typedef enum logic [2:0] {
      KIND_ABSORBED = 3'd0,
      KIND_PAYLOAD  = 3'd1,
      KIND_EMPTY    = 3'd2,
      KIND_END      = 3'd3,
      KIND_BADSIG   = 3'd4,
      KIND_IDLE     = 3'd5
   } kind_type;

   // one request item
   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
      logic       prior_cr;
   } item_type;

   // one result item
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload;
      logic       chunk_last;
   } result_type;

   // byte reversal of a 32-bit length
   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

`default_nettype wire

@@ design/ctd_parser.sv @@
// framing state and per-byte decode for the deframer
// depends on ctd_pkg; result is combinational from the held request
`default_nettype none

module ctd_parser
   import ctd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,      // commit the held request
   input  wire item_type   item,
   output      result_type result
);

   logic        active_ff, active_in;
   logic        skip_lf_ff, skip_lf_in;
   logic [2:0]  sig_count_ff, sig_count_in;
   logic [31:0] sig_shift_ff, sig_shift_in;
   logic        swap_ff, swap_in;
   logic [2:0]  len_count_ff, len_count_in;
   logic [31:0] remaining_ff, remaining_in;

   logic [31:0] sig_next;
   logic [31:0] len_next;
   logic [31:0] len_ordered;
   logic [31:0] rem_dec;

   assign sig_next    = {sig_shift_ff[23:0], item.data_byte};
   assign len_next    = {remaining_ff[23:0], item.data_byte};
   assign len_ordered = swap_ff ? swap32(len_next) : len_next;
   assign rem_dec     = remaining_ff - {31'd0, (remaining_ff != 32'd0)};

   // next state and result for the held request
   always_comb begin
      active_in    = active_ff;
      skip_lf_in   = skip_lf_ff;
      sig_count_in = sig_count_ff;
      sig_shift_in = sig_shift_ff;
      swap_in      = swap_ff;
      len_count_in = len_count_ff;
      remaining_in = remaining_ff;
      result       = '{kind: KIND_ABSORBED, payload: 8'd0, chunk_last: 1'b0};

      if (item.command == CMD_BEGIN) begin
         active_in    = 1'b1;
         skip_lf_in   = item.prior_cr;
         sig_count_in = 3'd0;
         sig_shift_in = 32'd0;
         len_count_in = 3'd0;
         remaining_in = 32'd0;
      end else if (!active_ff) begin
         result.kind = KIND_IDLE;
      end else begin
         skip_lf_in = 1'b0;
         if (skip_lf_ff && item.data_byte == LINE_FEED) begin
            result.kind = KIND_ABSORBED;
         end else if (sig_count_ff < FIELD_BYTES) begin
            // signature collection
            sig_shift_in = sig_next;
            sig_count_in = sig_count_ff + 3'd1;
            if (sig_count_in == FIELD_BYTES) begin
               if (sig_next == SIG_NATIVE) begin
                  swap_in = 1'b0;
               end else if (sig_next == SIG_SWAPPED) begin
                  swap_in = 1'b1;
               end else begin
                  active_in   = 1'b0;
                  result.kind = KIND_BADSIG;
               end
               len_count_in = 3'd0;
               remaining_in = 32'd0;
            end
         end else if (len_count_ff < FIELD_BYTES) begin
            // chunk length collection, end marker checked before swap
            remaining_in = len_next;
            len_count_in = len_count_ff + 3'd1;
            if (len_count_in == FIELD_BYTES) begin
               if (len_next == LEN_END) begin
                  active_in   = 1'b0;
                  result.kind = KIND_END;
               end else begin
                  remaining_in = len_ordered;
                  if (len_ordered == 32'd0) begin
                     result.kind  = KIND_EMPTY;
                     len_count_in = 3'd0;
                  end
               end
            end
         end else begin
            // payload byte
            result.kind    = KIND_PAYLOAD;
            result.payload = item.data_byte;
            remaining_in   = rem_dec;
            if (rem_dec == 32'd0) begin
               result.chunk_last = 1'b1;
               len_count_in      = 3'd0;
            end
         end
      end
   end

   // framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         skip_lf_ff   <= 1'b0;
         sig_count_ff <= 3'd0;
         sig_shift_ff <= 32'd0;
         swap_ff      <= 1'b0;
         len_count_ff <= 3'd0;
         remaining_ff <= 32'd0;
      end else if (step) begin
         active_ff    <= active_in;
         skip_lf_ff   <= skip_lf_in;
         sig_count_ff <= sig_count_in;
         sig_shift_ff <= sig_shift_in;
         swap_ff      <= swap_in;
         len_count_ff <= len_count_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

`default_nettype wire

@@ design/chunked_transmission_deframer.sv @@
// Chunked transmission deframer, top level.
// Each request carries one received byte or a begin command; each request
// yields exactly one result on the rsp channel (kind, payload, chunk_last).
// req_tuser is the command (1 begins a transmission, prior_cr in tdata then
// asks to drop one leading line feed); req_tdata carries the stream byte.
// Results: kind in rsp_tuser, payload byte in rsp_tdata, rsp_tlast marks
// the last payload byte of a chunk.
// An accepted request sits in an input register and moves through the
// decode into a result register once that register is free.
// Throughput: one request per cycle while the receiver does not stall;
// the framing state is updated when a request moves from the input
// register into the result register.
// When the receiver stalls, the result register holds, the input register
// keeps one more request, and req_tready drops once both are full.
// Reset (synchronous, active high) empties both registers and returns the
// framer to idle with native byte order.
// depends on ctd_pkg and ctd_parser
`default_nettype none

module chunked_transmission_deframer
   import ctd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [8] prior_cr, rest zero
   input  wire logic        req_tuser,   // [0] command
   // result channel
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // [7:0] payload
   output      logic [2:0]  rsp_tuser,   // [2:0] kind
   output      logic        rsp_tlast    // chunk_last
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type decoded;
   logic       advance;
   logic       req_accept;

   // pipeline control
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   ctd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (decoded)
   );

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.command   <= cmd_type'(req_tuser);
         in_item_ff.data_byte <= req_tdata[7:0];
         in_item_ff.prior_cr  <= req_tdata[8];
      end
   end

   // result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= decoded;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.payload;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.chunk_last;

`ifndef SYNTHESIS
   // payload byte only on payload results
   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PAYLOAD |-> rsp_tdata == 8'd0)
      else $error("payload nonzero on non-payload result");

   // chunk end flag only on payload results
   a_last_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == KIND_PAYLOAD)
      else $error("chunk_last on non-payload result");

   // no request taken while both registers are full and the receiver stalls
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted with full pipeline");

   // a held request reaches the result register once the output is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (!rsp_tvalid || rsp_tready) |=> rsp_tvalid)
      else $error("held request not moved to result register");
`endif

endmodule

`default_nettype wire

@@ test/tb_chunked_transmission_deframer.sv @@
// testbench for chunked_transmission_deframer: directed framing table, then random
// transmissions and noise, each result checked against its hand-typed row or an in-bench framing predictor
// depends on ctd_pkg and the chunked_transmission_deframer design sources
`timescale 1ns / 100ps

module tb_chunked_transmission_deframer;
   import ctd_pkg::*;

   // directed stimulus row, pinned rows carry a result typed in by hand
   typedef struct packed {
      cmd_type    c;
      logic [7:0] b;
      logic       cr;
      logic       pinned;
      kind_type   k;
      logic [7:0] p;
      logic       l;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;   // [7:0] data_byte, [8] prior_cr, rest zero
   logic        req_tuser = 1'b0;       // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;              // [7:0] payload
   logic [2:0]  rsp_tuser;              // [2:0] kind
   logic        rsp_tlast;

   // framing state mirrored by the predictor
   logic        framing_active = 1'b0;
   logic        drop_lf_pending = 1'b0;
   logic [2:0]  sig_bytes_seen = 3'd0;
   logic [31:0] sig_accum = 32'h0;
   logic        lengths_swapped = 1'b0;
   logic [2:0]  len_bytes_seen = 3'd0;
   logic [31:0] bytes_left = 32'h0;

   result_type   expected_rsp[$];
   stim_row_type stim_rows[$];
   int           mismatches = 0;
   int           sent_requests = 0;
   int           send_idle_pct = 20;
   int           recv_idle_pct = 58;

   chunked_transmission_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // run limit
   initial begin
      #3_000_000;
      $display("chunked_transmission_deframer test failed");
      $finish;
   end

   function automatic logic [31:0] byte_reverse(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // framing predictor: one request in, one result out, state advanced
   function automatic result_type deframe_step(cmd_type c, logic [7:0] b, logic cr);
      result_type r;
      logic       drop;
      r.kind = KIND_ABSORBED;
      r.payload = 8'h00;
      r.chunk_last = 1'b0;
      if (c == CMD_BEGIN) begin
         framing_active = 1'b1;
         drop_lf_pending = cr;
         sig_bytes_seen = 3'd0;
         sig_accum = 32'h0;
         len_bytes_seen = 3'd0;
         bytes_left = 32'h0;
      end else if (!framing_active) begin
         r.kind = KIND_IDLE;
      end else begin
         drop = drop_lf_pending && (b == LINE_FEED);
         drop_lf_pending = 1'b0;
         if (drop) begin
            r.kind = KIND_ABSORBED;
         end else if (sig_bytes_seen < FIELD_BYTES) begin
            sig_accum = {sig_accum[23:0], b};
            sig_bytes_seen = sig_bytes_seen + 3'd1;
            if (sig_bytes_seen == FIELD_BYTES) begin
               if (sig_accum == SIG_NATIVE) begin
                  lengths_swapped = 1'b0;
               end else if (sig_accum == SIG_SWAPPED) begin
                  lengths_swapped = 1'b1;
               end else begin
                  framing_active = 1'b0;
                  r.kind = KIND_BADSIG;
               end
               len_bytes_seen = 3'd0;
               bytes_left = 32'h0;
            end
         end else if (len_bytes_seen < FIELD_BYTES) begin
            bytes_left = {bytes_left[23:0], b};
            len_bytes_seen = len_bytes_seen + 3'd1;
            if (len_bytes_seen == FIELD_BYTES) begin
               // end marker is tested on the bytes as sent
               if (bytes_left == LEN_END) begin
                  framing_active = 1'b0;
                  r.kind = KIND_END;
               end else begin
                  if (lengths_swapped)
                     bytes_left = byte_reverse(bytes_left);
                  if (bytes_left == 32'h0) begin
                     r.kind = KIND_EMPTY;
                     len_bytes_seen = 3'd0;
                  end
               end
            end
         end else begin
            r.kind = KIND_PAYLOAD;
            r.payload = b;
            if (bytes_left != 32'h0)
               bytes_left = bytes_left - 32'd1;
            if (bytes_left == 32'h0) begin
               r.chunk_last = 1'b1;
               len_bytes_seen = 3'd0;
            end
         end
      end
      return r;
   endfunction

   // drive one request, wait for acceptance, queue its expected result
   task automatic send_request(cmd_type c, logic [7:0] b, logic cr,
                               bit pinned = 1'b0, result_type pinned_rsp = '0);
      result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, cr, b};
      req_tuser <= c;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = deframe_step(c, b, cr);
      expected_rsp.push_back(pinned ? pinned_rsp : predicted);
      sent_requests++;
   endtask

   // hold the request side until every outstanding result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_row(cmd_type c, logic [7:0] b, logic cr, logic pinned,
                          kind_type k, logic [7:0] p, logic l);
      stim_row_type row;
      row.c = c;
      row.b = b;
      row.cr = cr;
      row.pinned = pinned;
      row.k = k;
      row.p = p;
      row.l = l;
      stim_rows.push_back(row);
   endtask

   // one random transmission: begin, optional line feed, signature, then if valid chunks and mostly an end marker
   task automatic send_transmission();
      logic        cr;
      logic [31:0] sig;
      logic [31:0] wire_len;
      int          n_chunks;
      int          len;
      int          r;
      cr = 1'($urandom_range(1));
      send_request(CMD_BEGIN, 8'($urandom), cr);
      if (cr && $urandom_range(3) != 0)
         send_request(CMD_BYTE, LINE_FEED, 1'($urandom_range(1)));
      r = $urandom_range(9);
      sig = (r == 0) ? $urandom : (r < 6) ? SIG_NATIVE : SIG_SWAPPED;
      for (int i = 3; i >= 0; i--)
         send_request(CMD_BYTE, sig[8*i +: 8], 1'($urandom_range(1)));
      if (sig != SIG_NATIVE && sig != SIG_SWAPPED)
         return;
      n_chunks = $urandom_range(4);
      for (int k = 0; k < n_chunks; k++) begin
         r = $urandom_range(19);
         len = (r == 0) ? 0 : (r < 17) ? $urandom_range(1, 6) : $urandom_range(7, 40);
         wire_len = (sig == SIG_SWAPPED) ? byte_reverse(len) : len;
         for (int i = 3; i >= 0; i--)
            send_request(CMD_BYTE, wire_len[8*i +: 8], 1'($urandom_range(1)));
         for (int j = 0; j < len; j++) begin
            // rare cut in the middle of a chunk, the next begin restarts
            if ($urandom_range(199) == 0)
               return;
            send_request(CMD_BYTE, 8'($urandom), 1'($urandom_range(1)));
         end
      end
      // most transmissions close with the end marker
      if ($urandom_range(9) != 0)
         for (int i = 0; i < 4; i++)
            send_request(CMD_BYTE, 8'hFF, 1'($urandom_range(1)));
   endtask

   task automatic run_random(int goal);
      int n;
      while (sent_requests < goal) begin
         if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               send_request(($urandom_range(7) == 0) ? CMD_BEGIN : CMD_BYTE,
                            8'($urandom), 1'($urandom_range(1)));
         end else begin
            send_transmission();
         end
      end
   endtask

   // result side: random stall, compare against the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tuser);
            got.payload = rsp_tdata;
            got.chunk_last = rsp_tlast;
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected result: expected none, actual kind %0d payload %h last %b",
                        $time, got.kind, got.payload, got.chunk_last);
               mismatches++;
            end else begin
               want = expected_rsp.pop_front();
               if (got.kind != want.kind) begin
                  $display("%0t kind mismatch: expected %0d, actual %0d",
                           $time, want.kind, got.kind);
                  mismatches++;
               end
               if (got.payload != want.payload) begin
                  $display("%0t payload mismatch: expected %h, actual %h",
                           $time, want.payload, got.payload);
                  mismatches++;
               end
               if (got.chunk_last != want.chunk_last) begin
                  $display("%0t chunk_last mismatch: expected %b, actual %b",
                           $time, want.chunk_last, got.chunk_last);
                  mismatches++;
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      stim_row_type row;
      result_type   pinned_rsp;

      // byte before any begin, then begin with a pending line feed skip
      add_row(CMD_BYTE,  8'hFF,     1'b0, 1'b1, KIND_IDLE,     8'h00, 1'b0);
      add_row(CMD_BEGIN, 8'h00,     1'b1, 1'b1, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  LINE_FEED, 1'b1, 1'b1, KIND_ABSORBED, 8'h00, 1'b0);
      // native signature
      add_row(CMD_BYTE,  8'h01,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h02,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h03,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h04,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      // zero-length chunk
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b1, 1'b1, KIND_EMPTY,    8'h00, 1'b0);
      // end marker
      add_row(CMD_BYTE,  8'hFF,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'hFF,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'hFF,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'hFF,     1'b1, 1'b1, KIND_END,      8'h00, 1'b0);
      // skip armed but first byte is no line feed, swapped signature
      add_row(CMD_BEGIN, 8'hFF,     1'b1, 1'b1, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h04,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h03,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h02,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h01,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      // swapped length of one, single payload byte
      add_row(CMD_BYTE,  8'h01,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'hA5,     1'b1, 1'b1, KIND_PAYLOAD,  8'hA5, 1'b1);
      // restart while active, then a bad signature drops back to idle
      add_row(CMD_BEGIN, 8'h00,     1'b0, 1'b1, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h01,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h02,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h03,     1'b0, 1'b0, KIND_ABSORBED, 8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h05,     1'b0, 1'b1, KIND_BADSIG,   8'h00, 1'b0);
      add_row(CMD_BYTE,  8'h00,     1'b1, 1'b1, KIND_IDLE,     8'h00, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles 20 percent, receiver 58 percent
      send_idle_pct = 20;
      recv_idle_pct = 58;
      foreach (stim_rows[i]) begin
         row = stim_rows[i];
         pinned_rsp.kind = row.k;
         pinned_rsp.payload = row.p;
         pinned_rsp.chunk_last = row.l;
         send_request(row.c, row.b, row.cr, row.pinned, pinned_rsp);
      end
      run_random(sent_requests + 130);
      drain_results();

      // roles swapped
      send_idle_pct = 58;
      recv_idle_pct = 20;
      run_random(sent_requests + 135);

      // no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(sent_requests + 135);

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("chunked_transmission_deframer test passed");
      else
         $display("chunked_transmission_deframer test failed");
      $finish;
   end

endmodule
